/* sv/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Assertion that must also hold during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/cdq_pkg.sv */
// Types and constants of the circular deque unit.
package cdq_pkg;

  localparam int unsigned ActionW = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_REAR  = 3'd5
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_RESP = 1'b1
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // input transfer this cycle: execute request
    logic in_stall;
    logic out_valid;
  } dp_cmd_t;

endpackage

/* sv/circular_deque_unit.sv */
// Top level of the circular deque unit.
// Double-ended queue of DEPTH-1 signed 32-bit words in a ring of DEPTH slots.
// Input channel (in_valid_i / in_stall_o): action_i selects push front/rear,
// pop front/rear or peek front/rear; data_in_i is the word pushed.
// Output channel (out_valid_o / out_stall_i): one result per request with
// the word popped or peeked (zero otherwise), a status code (ok, full on
// push, empty on pop or peek) and the empty/full flags after the request.
// A request is executed at its input transfer; the result is valid in the
// next cycle and stays until transferred. One request is in flight at a
// time: a new request is taken only after the result is transferred.
// While the result is stalled, in_stall_o stays high.
// Reset empties the deque (both pointers zero); slot contents are not
// cleared, no entry is read before it is written.
module circular_deque_unit #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [cdq_pkg::ActionW-1:0]      action_i,
  input  logic signed [cdq_pkg::DataW-1:0] data_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [cdq_pkg::DataW-1:0] data_out_o,
  output logic [cdq_pkg::StatusW-1:0]      status_o,
  output logic                             is_empty_now_o,
  output logic                             is_full_now_o
);
  import cdq_pkg::*;

  `include "assert_macros.svh"

  dp_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (action_i),
    .data_in_i      (data_in_i),
    .data_out_o     (data_out_o),
    .status_o       (status_o),
    .is_empty_now_o (is_empty_now_o),
    .is_full_now_o  (is_full_now_o)
  );

  assign in_stall_o  = cmd.in_stall;
  assign out_valid_o = cmd.out_valid;

  `ASSERT_CLKRST(a_result_follows, clk_i, rst_ni,
    in_valid_i && !in_stall_o |=> out_valid_o, "no result after input transfer")
  `ASSERT_CLK(a_one_in_flight, clk_i,
    !(out_valid_o && !in_stall_o), "input open while a result is pending")
  `ASSERT_CLKRST(a_error_zero, clk_i, rst_ni,
    out_valid_o && status_o != ST_OK |-> data_out_o == '0, "error result carries data")
  `ASSERT_CLKRST(a_flags_exclusive, clk_i, rst_ni,
    out_valid_o |-> !(is_empty_now_o && is_full_now_o), "deque both empty and full")
  `ASSERT_CLKRST(a_empty_flag, clk_i, rst_ni,
    out_valid_o && status_o == ST_EMPTY |-> is_empty_now_o, "empty error, flag clear")

endmodule

/* sv/cdq_ctrl.sv */
// Controller FSM: one request in flight, result held until transferred.
module cdq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_stall_i,
  output cdq_pkg::dp_cmd_t cmd_o
);
  import cdq_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (in_valid_i) state_d = CS_RESP;
      end
      CS_RESP: begin
        if (!out_stall_i) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      CS_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      CS_RESP: begin
        cmd_o.in_stall  = 1'b1;
        cmd_o.out_valid = 1'b1;
      end
      default: cmd_o.in_stall = 1'b1;
    endcase
  end

endmodule

/* sv/cdq_datapath.sv */
// Datapath: ring pointers, slot memory and result registers.
module cdq_datapath #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cdq_pkg::dp_cmd_t              cmd_i,
  input  logic [cdq_pkg::ActionW-1:0]   action_i,
  input  logic signed [cdq_pkg::DataW-1:0] data_in_i,
  output logic signed [cdq_pkg::DataW-1:0] data_out_o,
  output logic [cdq_pkg::StatusW-1:0]   status_o,
  output logic                          is_empty_now_o,
  output logic                          is_full_now_o
);
  import cdq_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PtrW-1:0] ptr_prev(input logic [PtrW-1:0] p);
    return (p == '0) ? LastPtr : p - 1'b1;
  endfunction

  logic [DataW-1:0] mem [DEPTH];

  logic [PtrW-1:0] front_q, front_d, rear_q, rear_d;
  logic [PtrW-1:0] waddr, raddr;
  logic            we, re;
  logic            empty_c, full_c;
  status_e         status_c;

  logic [DataW-1:0] rd_data_q;
  logic             rd_ok_q;
  status_e          status_q;
  logic             empty_q, full_q;

  assign empty_c = (front_q == rear_q);
  assign full_c  = (ptr_next(rear_q) == front_q);

  always_comb begin
    front_d  = front_q;
    rear_d   = rear_q;
    waddr    = front_q;
    raddr    = rear_q;
    we       = 1'b0;
    re       = 1'b0;
    status_c = ST_OK;
    case (action_e'(action_i))
      ACT_PUSH_FRONT: begin
        if (full_c) begin
          status_c = ST_FULL;
        end else begin
          we      = 1'b1;
          waddr   = front_q;
          front_d = ptr_prev(front_q);
        end
      end
      ACT_PUSH_REAR: begin
        if (full_c) begin
          status_c = ST_FULL;
        end else begin
          we     = 1'b1;
          waddr  = ptr_next(rear_q);
          rear_d = ptr_next(rear_q);
        end
      end
      ACT_POP_FRONT: begin
        if (empty_c) begin
          status_c = ST_EMPTY;
        end else begin
          re      = 1'b1;
          raddr   = ptr_next(front_q);
          front_d = ptr_next(front_q);
        end
      end
      ACT_POP_REAR: begin
        if (empty_c) begin
          status_c = ST_EMPTY;
        end else begin
          re     = 1'b1;
          raddr  = rear_q;
          rear_d = ptr_prev(rear_q);
        end
      end
      ACT_PEEK_FRONT: begin
        if (empty_c) begin
          status_c = ST_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = ptr_next(front_q);
        end
      end
      ACT_PEEK_REAR: begin
        if (empty_c) begin
          status_c = ST_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = rear_q;
        end
      end
      default: ; // unused codes leave the state alone
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
    end else if (cmd_i.load) begin
      front_q <= front_d;
      rear_q  <= rear_d;
    end
  end

  // Single-port slot store, registered read; a request never reads and writes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && we) mem[waddr] <= data_in_i;
    if (cmd_i.load && re) rd_data_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_ok_q  <= re;
      status_q <= status_c;
      empty_q  <= (front_d == rear_d);
      full_q   <= (ptr_next(rear_d) == front_d);
    end
  end

  assign data_out_o     = rd_ok_q ? signed'(rd_data_q) : '0;
  assign status_o       = status_q;
  assign is_empty_now_o = empty_q;
  assign is_full_now_o  = full_q;

endmodule
